FILE: hw/rtl/f2fc_pkg.sv
// Shared types and constants of the float to fixed-point converter.
`timescale 1ns / 1ps
package f2fc_pkg;
    localparam int FracBitsDefault = 32;
    localparam int SigW  = 53;
    localparam int ShW   = 12;
    localparam int DataW = 64;

    localparam logic [DataW-1:0] PosSat = {1'b0, {(DataW-1){1'b1}}};
    localparam logic [DataW-1:0] NegSat = {1'b1, {(DataW-1){1'b0}}};

    localparam logic ReqSingle = 1'b0;
    localparam logic ReqDouble = 1'b1;

    typedef struct packed {
        logic                   neg;
        logic                   is_nan;
        logic                   is_inf;
        logic [SigW-1:0]        sig;
        logic signed [ShW-1:0]  sh;
    } t_dec;
endpackage

FILE: hw/rtl/f2fc_if.sv
// Handshake channels of the converter: request and response.
`timescale 1ns / 1ps
interface f2fc_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [63:0] float_bits;
    modport source (output valid, output req_type, output float_bits, input ready);
    modport sink (input valid, input req_type, input float_bits, output ready);
endinterface

interface f2fc_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] fixed_value;
    modport source (output valid, output fixed_value, input ready);
    modport sink (input valid, input fixed_value, output ready);
endinterface

FILE: hw/rtl/float_to_fixed_converter.sv
// Top level of the IEEE-754 to signed 64-bit fixed-point converter.
// Usage:
//   i_req carries one request: req_type (0 single precision in the low 32
//   bits of float_bits, 1 double precision) and the raw float_bits word.
//   o_rsp returns fixed_value, the input times 2^FRAC_BITS, rounded to
//   nearest with ties to even and saturated to the signed 64-bit range.
//   NaN gives 0; infinities clamp to the matching extreme.
// Pipeline: the accepting edge loads the input register; decode, shift and
//   round then settle into the result register when it advances, and the
//   response is held there until the receiver takes it.
// Throughput: one request per cycle while the receiver keeps ready high, set by
//   the single decode/shift/round path between the two registers.
// Stall: when the receiver holds ready low, the result register holds its
//   value and the input register can still take one more request; ready on
//   i_req drops only when both are full.
// Reset: i_rst_n (synchronous, active low) empties both registers; their
//   payload bits are not reset.
`timescale 1ns / 1ps
module float_to_fixed_converter #(
    parameter int FRAC_BITS = f2fc_pkg::FracBitsDefault
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    f2fc_req_if.sink     i_req,
    f2fc_rsp_if.source   o_rsp
);
    import f2fc_pkg::*;

    logic        r_in_valid, n_in_valid;
    logic        r_in_type;
    logic [63:0] r_in_bits;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_value;

    logic  out_adv;
    t_dec  dec;
    logic [63:0] value;

    // advance the result register when it is empty or being taken
    assign out_adv     = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || out_adv;
    assign n_in_valid  = i_req.ready ? i_req.valid : r_in_valid;
    assign n_out_valid = out_adv ? r_in_valid : r_out_valid;

    f2fc_decode #(.FRAC_BITS(FRAC_BITS)) u_decode (
        .i_req_type   (r_in_type),
        .i_float_bits (r_in_bits),
        .o_dec        (dec)
    );

    f2fc_scale u_scale (
        .i_dec   (dec),
        .o_value (value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: load the input on acceptance, hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (i_req.ready) begin
            r_in_type <= i_req.req_type;
            r_in_bits <= i_req.float_bits;
        end
        if (out_adv) begin
            r_out_value <= value;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.fixed_value = r_out_value;

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid)
        else $error("pending response dropped");

    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_in_valid)
        else $error("accepted request lost");

    a_nan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_adv && dec.is_nan |=> r_out_value == 64'd0)
        else $error("NaN did not give zero");

    a_inf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_adv && dec.is_inf && !dec.neg |=> r_out_value == PosSat)
        else $error("plus infinity did not saturate");
endmodule

FILE: hw/rtl/f2fc_decode.sv
// Field decode of a single or double precision word.
`timescale 1ns / 1ps
module f2fc_decode #(
    parameter int FRAC_BITS = f2fc_pkg::FracBitsDefault
) (
    input  logic             i_req_type,
    input  logic [63:0]      i_float_bits,
    output f2fc_pkg::t_dec   o_dec
);
    import f2fc_pkg::*;

    logic [10:0] expf;
    logic [51:0] frac;
    logic        all_ones;
    logic        zero_exp;
    logic signed [ShW-1:0] bias_ex;

    always_comb begin
        if (i_req_type == ReqSingle) begin
            o_dec.neg = i_float_bits[31];
            expf      = {3'b0, i_float_bits[30:23]};
            frac      = {29'b0, i_float_bits[22:0]};
            all_ones  = &i_float_bits[30:23];
            zero_exp  = ~|i_float_bits[30:23];
            o_dec.sig = {29'b0, ~zero_exp, i_float_bits[22:0]};
            bias_ex   = zero_exp ? ShW'(-149) : ShW'($signed({1'b0, expf}) - 150);
        end else begin
            o_dec.neg = i_float_bits[63];
            expf      = i_float_bits[62:52];
            frac      = i_float_bits[51:0];
            all_ones  = &expf;
            zero_exp  = ~|expf;
            o_dec.sig = {~zero_exp, frac};
            bias_ex   = zero_exp ? ShW'(-1074) : ShW'($signed({1'b0, expf}) - 1075);
        end
        o_dec.is_nan = all_ones && (|frac);
        o_dec.is_inf = all_ones && !(|frac);
        o_dec.sh     = bias_ex + ShW'(FRAC_BITS);
    end
endmodule

FILE: hw/rtl/f2fc_scale.sv
// Scale, round to nearest even, saturate and apply sign.
`timescale 1ns / 1ps
module f2fc_scale (
    input  f2fc_pkg::t_dec    i_dec,
    output logic [63:0]       o_value
);
    import f2fc_pkg::*;

    logic [127:0] wide;
    logic [ShW-1:0] r;
    logic [63:0] mag;
    logic        sat;
    logic        up;

    always_comb begin
        wide = '0;
        r    = '0;
        up   = 1'b0;
        sat  = 1'b0;
        mag  = '0;
        if (!i_dec.sh[ShW-1]) begin
            wide = {75'b0, i_dec.sig} << i_dec.sh[5:0];
            sat  = (i_dec.sh > ShW'(62)) || (|wide[127:63]);
            mag  = wide[63:0];
        end else begin
            r = -i_dec.sh;
            if (r < ShW'(64)) begin
                wide = {11'b0, i_dec.sig, 64'b0} >> r[5:0];
                up   = wide[63] && ((|wide[62:0]) || wide[64]);
                mag  = wide[127:64] + {63'b0, up};
            end
        end
        // specials first: NaN and zero clear, infinity and overflow clamp
        if (i_dec.is_nan || (!i_dec.is_inf && i_dec.sig == '0)) begin
            o_value = '0;
        end else if (i_dec.is_inf || sat) begin
            o_value = i_dec.neg ? NegSat : PosSat;
        end else begin
            o_value = i_dec.neg ? (64'd0 - mag) : mag;
        end
    end
endmodule
